// ===== design/lzsd_pkg.sv =====
// lzsd_pkg: shared types and constants for the lzss bit-stream decoder
// no dependencies; used by the interfaces and the top level
`default_nettype none

package lzsd_pkg;

  localparam int BYTE_W              = 8;
  localparam int SHIFT_CNT_W         = 4;
  localparam int COUNT_W             = 16;
  localparam int DEFAULT_WINDOW_BITS = 8;
  localparam int DEFAULT_LENGTH_BITS = 4;

  localparam logic [SHIFT_CNT_W-1:0] SHIFT_FULL    = SHIFT_CNT_W'(BYTE_W);
  localparam logic [COUNT_W-1:0]     MAX_OUT_RESET = {COUNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_BITS,
    ST_COPY_RD,
    ST_COPY_EM,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LITERAL,
    PH_LENGTH,
    PH_OFFSET
  } phase_t;

endpackage

`default_nettype wire

// ===== design/lzsd_stream_if.sv =====
// lzsd_in_if / lzsd_out_if: valid-ready channels for compressed and decoded beats
// depends on lzsd_pkg
`default_nettype none

interface lzsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [lzsd_pkg::BYTE_W-1:0] data_byte;
  logic                        final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface lzsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lzsd_pkg::BYTE_W-1:0] out_byte;
  logic                        from_history;
  logic                        last_of_run;
  logic                        limit_reached;

  modport source (output valid, output out_byte, output from_history,
                  output last_of_run, output limit_reached, input ready);
  modport sink   (input valid, input out_byte, input from_history,
                  input last_of_run, input limit_reached, output ready);
endinterface

`default_nettype wire

// ===== design/lzsd_ram.sv =====
// lzsd_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lzss_bitstream_decoder_top.sv =====
// lzss_bitstream_decoder_top: lzss decoder with a flag/code bit shifter and history ring
// depends on lzsd_pkg, lzsd_stream_if.sv and lzsd_ram
//
//   channel   dir   beat contents
//   in_ch     in    data_byte[7:0], final_byte
//   out_ch    out   out_byte[7:0], from_history, last_of_run, limit_reached
//   cfg       in    cfg_we, cfg_data[15:0] -> max_output_bytes
//
// an input beat is accepted only in idle, then passes start, bits (skipped once the stream
// is done) and flush before the next accept; bits takes one flag/code bit per cycle
// (up to 8), a copied byte takes one ram read then one emit, and each completed reference
// ends with one more copy read; a single bit sequencer and one ram read port set this order.
// each decoded byte waits in a hold register until the next one is known, so
// last_of_run is exact; a stalled output stalls the sequencer at an emit or at beat end.
// synchronous reset clears control state; ring contents are not cleared.
`default_nettype none

module lzss_bitstream_decoder_top #(
  parameter int WINDOW_BITS = lzsd_pkg::DEFAULT_WINDOW_BITS,
  parameter int LENGTH_BITS = lzsd_pkg::DEFAULT_LENGTH_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lzsd_pkg::COUNT_W-1:0] cfg_data,
  lzsd_in_if.sink                           in_ch,
  lzsd_out_if.source                        out_ch
);

  localparam int FW    = (WINDOW_BITS > LENGTH_BITS) ? WINDOW_BITS : LENGTH_BITS;
  localparam int FBW   = $clog2(FW + 1);
  localparam int CLW   = LENGTH_BITS + 1;
  localparam int DEPTH = 1 << WINDOW_BITS;
  localparam int BW    = lzsd_pkg::BYTE_W;
  localparam int CW    = lzsd_pkg::COUNT_W;
  localparam int SW    = lzsd_pkg::SHIFT_CNT_W;

  lzsd_pkg::state_t state, state_next;
  lzsd_pkg::phase_t phase, phase_next;

  logic [CW-1:0]          max_output_bytes;
  logic [BW-1:0]          in_byte;
  logic                   in_final;
  logic [BW-1:0]          bit_shifter, bit_shifter_next;
  logic [SW-1:0]          bits_remaining, bits_remaining_next;
  logic [FW-1:0]          field_value, field_value_next;
  logic [FBW-1:0]         field_bits_left, field_bits_left_next;
  logic [CLW-1:0]         copy_length, copy_length_next;
  logic [CW-1:0]          produced_count, produced_count_next;
  logic                   stream_done, stream_done_next;

  logic                   hold_valid, hold_valid_next;
  logic [BW-1:0]          hold_byte, hold_byte_next;
  logic                   hold_hist, hold_hist_next;
  logic                   hold_limit, hold_limit_next;

  logic                   out_valid_next;
  logic [BW-1:0]          out_byte_next;
  logic                   out_hist_next, out_last_next, out_limit_next;

  logic                   ram_we, ram_re;
  logic [WINDOW_BITS-1:0] ram_waddr, ram_raddr;
  logic [BW-1:0]          ram_wdata, ram_rdata;

  logic                   out_free, slot_ok, done_now;
  logic                   emit_req, emit_go, bit_go, copy_go, flush_go;
  logic                   cur_bit, offset_done;
  logic [FW-1:0]          field_shift;
  logic [CW-1:0]          offset_ext, count_inc;
  logic [BW-1:0]          emit_byte;

  assign in_ch.ready = (state == lzsd_pkg::ST_IDLE);
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign slot_ok     = !hold_valid || out_free;
  assign done_now    = stream_done || (produced_count >= max_output_bytes);
  assign offset_ext  = CW'(field_value[WINDOW_BITS-1:0]);
  assign count_inc   = produced_count + 1'b1;
  assign cur_bit     = bit_shifter[BW-1];
  assign field_shift = {field_value[FW-2:0], cur_bit};

  assign emit_req = ((state == lzsd_pkg::ST_START) && !done_now
                     && (phase == lzsd_pkg::PH_LITERAL))
                    || (state == lzsd_pkg::ST_COPY_EM);
  assign emit_go  = emit_req && slot_ok;
  assign emit_byte = (state == lzsd_pkg::ST_COPY_EM) ? ram_rdata : in_byte;
  assign bit_go   = (state == lzsd_pkg::ST_BITS) && (bits_remaining != '0)
                    && !stream_done && (phase != lzsd_pkg::PH_LITERAL);
  assign offset_done = bit_go && (phase == lzsd_pkg::PH_OFFSET)
                       && (field_bits_left == FBW'(1));
  assign copy_go  = (state == lzsd_pkg::ST_COPY_RD) && (copy_length != '0)
                    && !stream_done && (offset_ext != '0)
                    && (offset_ext <= produced_count);
  assign flush_go = (state == lzsd_pkg::ST_FLUSH) && slot_ok;

  assign ram_we    = emit_go;
  assign ram_waddr = produced_count[WINDOW_BITS-1:0];
  assign ram_wdata = emit_byte;
  assign ram_re    = copy_go;
  assign ram_raddr = produced_count[WINDOW_BITS-1:0] - field_value[WINDOW_BITS-1:0];

  lzsd_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lzsd_pkg::ST_IDLE: begin
        if (in_ch.valid) state_next = lzsd_pkg::ST_START;
      end
      lzsd_pkg::ST_START: begin
        if (done_now) state_next = lzsd_pkg::ST_FLUSH;
        else if (phase != lzsd_pkg::PH_LITERAL || emit_go) state_next = lzsd_pkg::ST_BITS;
      end
      lzsd_pkg::ST_BITS: begin
        if (!bit_go) state_next = lzsd_pkg::ST_FLUSH;
        else if (offset_done) state_next = lzsd_pkg::ST_COPY_RD;
      end
      lzsd_pkg::ST_COPY_RD: begin
        state_next = copy_go ? lzsd_pkg::ST_COPY_EM : lzsd_pkg::ST_BITS;
      end
      lzsd_pkg::ST_COPY_EM: begin
        if (emit_go) state_next = lzsd_pkg::ST_COPY_RD;
      end
      lzsd_pkg::ST_FLUSH: begin
        if (flush_go) state_next = lzsd_pkg::ST_IDLE;
      end
      default: state_next = lzsd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_next           = phase;
    bit_shifter_next     = bit_shifter;
    bits_remaining_next  = bits_remaining;
    field_value_next     = field_value;
    field_bits_left_next = field_bits_left;
    copy_length_next     = copy_length;
    produced_count_next  = produced_count;
    stream_done_next     = stream_done;
    hold_valid_next      = hold_valid;
    hold_byte_next       = hold_byte;
    hold_hist_next       = hold_hist;
    hold_limit_next      = hold_limit;
    out_valid_next       = out_ch.valid && !out_ch.ready;
    out_byte_next        = out_ch.out_byte;
    out_hist_next        = out_ch.from_history;
    out_last_next        = out_ch.last_of_run;
    out_limit_next       = out_ch.limit_reached;

    if (state == lzsd_pkg::ST_START) begin
      stream_done_next = done_now;
      if (!done_now && phase != lzsd_pkg::PH_LITERAL) begin
        bit_shifter_next    = in_byte;
        bits_remaining_next = lzsd_pkg::SHIFT_FULL;
      end else if (!done_now && emit_go) begin
        phase_next = lzsd_pkg::PH_FLAG;
      end
    end

    if (bit_go) begin
      bit_shifter_next    = {bit_shifter[BW-2:0], 1'b0};
      bits_remaining_next = bits_remaining - 1'b1;
      unique case (phase)
        lzsd_pkg::PH_FLAG: begin
          if (cur_bit) begin
            phase_next = lzsd_pkg::PH_LITERAL;
          end else begin
            phase_next           = lzsd_pkg::PH_LENGTH;
            field_value_next     = '0;
            field_bits_left_next = FBW'(LENGTH_BITS);
          end
        end
        lzsd_pkg::PH_LENGTH: begin
          field_value_next     = field_shift;
          field_bits_left_next = field_bits_left - 1'b1;
          if (field_bits_left == FBW'(1)) begin
            copy_length_next     = CLW'(field_shift[LENGTH_BITS-1:0]) + 1'b1;
            phase_next           = lzsd_pkg::PH_OFFSET;
            field_value_next     = '0;
            field_bits_left_next = FBW'(WINDOW_BITS);
          end
        end
        lzsd_pkg::PH_OFFSET: begin
          field_value_next     = field_shift;
          field_bits_left_next = field_bits_left - 1'b1;
          if (field_bits_left == FBW'(1)) phase_next = lzsd_pkg::PH_FLAG;
        end
        default: ;
      endcase
    end

    // copy finished or refused
    if (state == lzsd_pkg::ST_COPY_RD && !copy_go) field_value_next = '0;

    if (emit_go) begin
      if (hold_valid) begin
        out_valid_next = 1'b1;
        out_byte_next  = hold_byte;
        out_hist_next  = hold_hist;
        out_last_next  = 1'b0;
        out_limit_next = hold_limit;
      end
      hold_valid_next     = 1'b1;
      hold_byte_next      = emit_byte;
      hold_hist_next      = (state == lzsd_pkg::ST_COPY_EM);
      hold_limit_next     = (count_inc >= max_output_bytes);
      produced_count_next = count_inc;
      stream_done_next    = (count_inc >= max_output_bytes);
      if (state == lzsd_pkg::ST_COPY_EM) copy_length_next = copy_length - 1'b1;
    end

    if (flush_go) begin
      if (hold_valid) begin
        out_valid_next = 1'b1;
        out_byte_next  = hold_byte;
        out_hist_next  = hold_hist;
        out_last_next  = 1'b1;
        out_limit_next = hold_limit;
      end
      hold_valid_next = 1'b0;
      if (in_final) begin
        phase_next           = lzsd_pkg::PH_FLAG;
        bit_shifter_next     = '0;
        bits_remaining_next  = '0;
        field_value_next     = '0;
        field_bits_left_next = '0;
        copy_length_next     = '0;
        produced_count_next  = '0;
        stream_done_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= lzsd_pkg::ST_IDLE;
      phase            <= lzsd_pkg::PH_FLAG;
      max_output_bytes <= lzsd_pkg::MAX_OUT_RESET;
      bit_shifter      <= '0;
      bits_remaining   <= '0;
      field_value      <= '0;
      field_bits_left  <= '0;
      copy_length      <= '0;
      produced_count   <= '0;
      stream_done      <= 1'b0;
      hold_valid       <= 1'b0;
      out_ch.valid     <= 1'b0;
    end else begin
      state            <= state_next;
      phase            <= phase_next;
      bit_shifter      <= bit_shifter_next;
      bits_remaining   <= bits_remaining_next;
      field_value      <= field_value_next;
      field_bits_left  <= field_bits_left_next;
      copy_length      <= copy_length_next;
      produced_count   <= produced_count_next;
      stream_done      <= stream_done_next;
      hold_valid       <= hold_valid_next;
      out_ch.valid     <= out_valid_next;
      if (cfg_we) max_output_bytes <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte  <= in_ch.data_byte;
      in_final <= in_ch.final_byte;
    end
    hold_byte            <= hold_byte_next;
    hold_hist            <= hold_hist_next;
    hold_limit           <= hold_limit_next;
    out_ch.out_byte      <= out_byte_next;
    out_ch.from_history  <= out_hist_next;
    out_ch.last_of_run   <= out_last_next;
    out_ch.limit_reached <= out_limit_next;
  end

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == lzsd_pkg::ST_IDLE) |-> !hold_valid)
    else $error("held beat left behind at end of input beat");

  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    (state == lzsd_pkg::ST_COPY_EM) |->
      ($past(state) == lzsd_pkg::ST_COPY_RD || $past(state) == lzsd_pkg::ST_COPY_EM))
    else $error("copy emit without a preceding ring read");

  a_copy_offset: assert property (@(posedge clk) disable iff (rst)
    (state == lzsd_pkg::ST_COPY_EM) |-> (offset_ext != '0 && offset_ext <= produced_count))
    else $error("copy from an offset outside the produced output");

  a_limit_done: assert property (@(posedge clk) disable iff (rst)
    (emit_go && count_inc >= max_output_bytes) |=> stream_done)
    else $error("output limit reached without ending the stream");

endmodule

`default_nettype wire
